// ----- rtl/etwc_pkg.sv -----
// ----------------------------------------------------------------------------
// etwc_pkg
// shared types and constants of the event triggered window capture unit
// ----------------------------------------------------------------------------
package etwc_pkg;

  localparam int SAMPLE_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int WINDOW_MAX   = 64;
  localparam int WL_W         = 7;
  localparam int MEAN_TAPS    = 10;
  localparam int TAP_W        = $clog2(MEAN_TAPS);
  localparam int SUM_W        = 20;
  // floor((s + 5) / 10) with s biased non-negative by ten times 32768
  localparam int MEAN_BIAS    = 5 + 10 * 32768;
  localparam int MEAN_UNBIAS  = 32768;
  localparam int RECIP        = 838861;
  localparam int RECIP_SHIFT  = 23;
  localparam int PROD_W       = 2 * SUM_W;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_EVENT  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_WINDOW  = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_ABORTED = 2'd2
  } status_t;

  typedef enum logic {
    CFG_PRE_WINDOW    = 1'b0,
    CFG_WINDOW_LENGTH = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_ADDR,
    ST_SRCH_CMP,
    ST_SUM_RD,
    ST_SUM_WAIT,
    ST_MEAN_MUL,
    ST_MEAN_FIN,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [31:0]        stamp;
    logic signed [15:0] value;
  } entry_t;

endpackage

// ----- rtl/event_triggered_window_capture_unit.sv -----
// ----------------------------------------------------------------------------
// event_triggered_window_capture_unit
// stores timestamped samples and, per event, emits a baseline corrected window
//
//   channel | ports                                     | handshake
//   --------+-------------------------------------------+---------------------
//   input   | in_operation in_sample_value in_sample_time | start high, busy low
//           | in_event_time                             |
//   result  | out_trace_value out_sample_index out_last | out_valid strobe
//           | out_status                                |
//   config  | cfg_index cfg_wdata                       | cfg_we
//
// clear, append and any event while aborted are handled without leaving idle
// an event searches past the s earlier samples on the single memory read port,
//   reads ten taps for the mean and then emits one result per cycle for the wl
//   window words
// synchronous reset empties the store by zeroing the fill count, no memory sweep
// results cannot be held off, each is valid for exactly one cycle
// ----------------------------------------------------------------------------
module event_triggered_window_capture_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic signed [15:0] in_sample_value,
  input  logic [31:0]        in_sample_time,
  input  logic [31:0]        in_event_time,
  output logic               out_valid,
  output logic signed [16:0] out_trace_value,
  output logic [5:0]         out_sample_index,
  output logic               out_last,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_wdata
);
  import etwc_pkg::*;

  state_t state_r, state_nxt;

  logic [23:0]            pre_window_r;
  logic [WL_W-1:0]        window_length_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       ptr_r, ptr_nxt;
  logic                   aborted_r, aborted_nxt;
  logic signed [32:0]     thr_r, thr_nxt;
  logic [WL_W-1:0]        wl_r, wl_nxt;
  logic [TAP_W-1:0]       tap_r, tap_nxt;
  logic [WL_W-1:0]        k_r, k_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                   acc_v_r;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [16:0]     mean_r, mean_nxt;

  logic                   p1_v_r;
  logic [5:0]             p1_k_r;
  logic                   p1_inr_r;
  logic                   p1_last_r;

  logic                   out_valid_r, out_valid_nxt;
  logic signed [16:0]     out_trace_r, out_trace_nxt;
  logic [5:0]             out_idx_r, out_idx_nxt;
  logic                   out_last_r, out_last_nxt;
  status_t                out_status_r, out_status_nxt;

  logic                   accept;
  op_t                    op;
  logic                   ptr_at_end;
  logic                   time_lt;
  logic                   tail_short;
  logic                   emit_done;
  logic [CNT_W:0]         emit_pos;
  logic [SUM_W-1:0]       mean_arg;
  logic [WL_W-1:0]        wl_eff;

  logic                   wr_en;
  entry_t                 wr_data;
  logic [ADDR_W-1:0]      rd_addr;
  entry_t                 rd_data;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign op         = op_t'(in_operation);
  assign ptr_at_end = (ptr_r >= count_r);
  assign time_lt    = ($signed({1'b0, rd_data.stamp}) < thr_r);
  assign tail_short = (({1'b0, ptr_r} + (CNT_W+1)'(MEAN_TAPS - 1)) >= {1'b0, count_r});
  assign emit_done  = ((k_r + WL_W'(1)) == wl_r);
  assign emit_pos   = {1'b0, ptr_r} + (CNT_W+1)'(k_r);
  assign mean_arg   = SUM_W'(sum_r) + SUM_W'(MEAN_BIAS);

  always_comb begin
    if (window_length_r == '0) begin
      wl_eff = WL_W'(1);
    end else if (window_length_r > WL_W'(WINDOW_MAX)) begin
      wl_eff = WL_W'(WINDOW_MAX);
    end else begin
      wl_eff = window_length_r;
    end
  end

  assign wr_en         = accept && (op == OP_APPEND) && (count_r < CNT_W'(SAMPLE_DEPTH));
  assign wr_data.stamp = in_sample_time;
  assign wr_data.value = in_sample_value;

  always_comb begin
    case (state_r)
      ST_SUM_RD: rd_addr = ADDR_W'(ptr_r + CNT_W'(tap_r));
      ST_EMIT:   rd_addr = ADDR_W'(emit_pos);
      default:   rd_addr = ADDR_W'(ptr_r);
    endcase
  end

  etwc_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(count_r)),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (op == OP_EVENT) && !aborted_r) begin
          state_nxt = ST_SRCH_ADDR;
        end
      end
      ST_SRCH_ADDR: begin
        state_nxt = ptr_at_end ? ST_IDLE : ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (time_lt) begin
          state_nxt = ST_SRCH_ADDR;
        end else if (tail_short) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SUM_RD;
        end
      end
      ST_SUM_RD: begin
        if (tap_r == TAP_W'(MEAN_TAPS - 1)) begin
          state_nxt = ST_SUM_WAIT;
        end
      end
      ST_SUM_WAIT: state_nxt = ST_MEAN_MUL;
      ST_MEAN_MUL: state_nxt = ST_MEAN_FIN;
      ST_MEAN_FIN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result word
  always_comb begin
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    aborted_nxt    = aborted_r;
    thr_nxt        = thr_r;
    wl_nxt         = wl_r;
    tap_nxt        = tap_r;
    k_nxt          = k_r;
    sum_nxt        = sum_r;
    prod_nxt       = prod_r;
    mean_nxt       = mean_r;
    out_valid_nxt  = 1'b0;
    out_trace_nxt  = out_trace_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    if (acc_v_r) begin
      sum_nxt = sum_r + SUM_W'(rd_data.value);
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_CLEAR: begin
              count_nxt   = '0;
              ptr_nxt     = '0;
              aborted_nxt = 1'b0;
            end
            OP_APPEND: begin
              if (wr_en) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_EVENT: begin
              if (aborted_r) begin
                out_valid_nxt  = 1'b1;
                out_trace_nxt  = '0;
                out_idx_nxt    = '0;
                out_last_nxt   = 1'b1;
                out_status_nxt = STAT_ABORTED;
              end else begin
                thr_nxt = $signed({1'b0, in_event_time}) - $signed({9'd0, pre_window_r});
                wl_nxt  = wl_eff;
                tap_nxt = '0;
                k_nxt   = '0;
                sum_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SRCH_ADDR: begin
        if (ptr_at_end) begin
          aborted_nxt    = 1'b1;
          out_valid_nxt  = 1'b1;
          out_trace_nxt  = '0;
          out_idx_nxt    = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = STAT_MISSING;
        end
      end
      ST_SRCH_CMP: begin
        if (time_lt) begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end else if (tail_short) begin
          aborted_nxt    = 1'b1;
          out_valid_nxt  = 1'b1;
          out_trace_nxt  = '0;
          out_idx_nxt    = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = STAT_MISSING;
        end
      end
      ST_SUM_RD: begin
        tap_nxt = tap_r + TAP_W'(1);
      end
      ST_MEAN_MUL: begin
        prod_nxt = PROD_W'(mean_arg) * PROD_W'(RECIP);
      end
      ST_MEAN_FIN: begin
        mean_nxt = $signed(17'(prod_r >> RECIP_SHIFT)) - 17'(MEAN_UNBIAS);
      end
      ST_EMIT: begin
        k_nxt = k_r + WL_W'(1);
      end
      default: begin
      end
    endcase

    if (p1_v_r) begin
      out_valid_nxt  = 1'b1;
      out_trace_nxt  = p1_inr_r ? (17'(rd_data.value) - mean_r) : '0;
      out_idx_nxt    = p1_k_r;
      out_last_nxt   = p1_last_r;
      out_status_nxt = STAT_WINDOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      pre_window_r    <= '0;
      window_length_r <= WL_W'(WINDOW_MAX);
      count_r         <= '0;
      ptr_r           <= '0;
      aborted_r       <= 1'b0;
      acc_v_r         <= 1'b0;
      p1_v_r          <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      aborted_r   <= aborted_nxt;
      acc_v_r     <= (state_r == ST_SUM_RD);
      p1_v_r      <= (state_r == ST_EMIT);
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PRE_WINDOW:    pre_window_r    <= cfg_wdata;
          CFG_WINDOW_LENGTH: window_length_r <= cfg_wdata[WL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    thr_r        <= thr_nxt;
    wl_r         <= wl_nxt;
    tap_r        <= tap_nxt;
    k_r          <= k_nxt;
    sum_r        <= sum_nxt;
    prod_r       <= prod_nxt;
    mean_r       <= mean_nxt;
    p1_k_r       <= 6'(k_r);
    p1_inr_r     <= (emit_pos < (CNT_W+1)'(count_r));
    p1_last_r    <= emit_done;
    out_trace_r  <= out_trace_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_trace_value  = out_trace_r;
  assign out_sample_index = out_idx_r;
  assign out_last         = out_last_r;
  assign out_status       = out_status_r;

  a_ptr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= count_r)
    else $error("search pointer beyond fill count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SAMPLE_DEPTH))
    else $error("fill count beyond store depth");

  a_event_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (op == OP_EVENT) && !aborted_r) |=> busy)
    else $error("event did not start the sequencer");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_WINDOW)) |-> (out_last_r && (out_idx_r == '0)))
    else $error("error result not a single last word");

  a_missing_aborts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_MISSING)) |-> aborted_r)
    else $error("missing data without abort flag");

endmodule

// ----- rtl/etwc_store.sv -----
// ----------------------------------------------------------------------------
// etwc_store
// sample and timestamp memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module etwc_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [etwc_pkg::ADDR_W-1:0] wr_addr,
  input  etwc_pkg::entry_t            wr_data,
  input  logic [etwc_pkg::ADDR_W-1:0] rd_addr,
  output etwc_pkg::entry_t            rd_data
);
  import etwc_pkg::*;

  entry_t mem [SAMPLE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- bench/event_triggered_window_capture_unit_tb.sv -----
// ----------------------------------------------------------------------------
// event_triggered_window_capture_unit_tb
// self-checking bench for the event triggered window capture unit
//
// Command words (clear, append, event, unused code) are queued by an initial
// block and presented by a driver with random start gaps. Every accepted
// word also goes through a predictor in the bench. It keeps its own sample
// store, search pointer, abort flag and register copies, and queues the
// window words that each event should produce. A monitor checks every
// out_valid strobe field by field against the oldest queued word.
//
// The run covers:
//   - missing data and aborted events on an empty and on a short store
//   - mean extremes, window positions past the end of the data
//   - negative search thresholds, window lengths of 0 and above 64
//   - random event bursts under changing register settings
// Registers are only written while the unit is idle.
// ----------------------------------------------------------------------------
module event_triggered_window_capture_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etwc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 40;
  localparam int RANDOM_WORDS = 270;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] value;
    logic [31:0]        stamp;
    logic [31:0]        ev;
  } word_t;

  typedef struct packed {
    logic signed [16:0] trace;
    logic [5:0]         idx;
    logic               last;
    status_t            status;
  } trace_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_operation = OP_CLEAR;
  logic signed [15:0] in_sample_value = '0;
  logic [31:0]        in_sample_time = '0;
  logic [31:0]        in_event_time = '0;
  logic               out_valid;
  logic signed [16:0] out_trace_value;
  logic [5:0]         out_sample_index;
  logic               out_last;
  logic [1:0]         out_status;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_PRE_WINDOW;
  logic [23:0]        cfg_wdata = '0;

  event_triggered_window_capture_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_sample_value  (in_sample_value),
    .in_sample_time   (in_sample_time),
    .in_event_time    (in_event_time),
    .out_valid        (out_valid),
    .out_trace_value  (out_trace_value),
    .out_sample_index (out_sample_index),
    .out_last         (out_last),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state
  logic signed [15:0] sample_mem [SAMPLE_DEPTH];
  logic [31:0]        stamp_mem [SAMPLE_DEPTH];
  logic [CNT_W-1:0]   fill = '0;
  logic [CNT_W-1:0]   seek = '0;
  logic               halted = 1'b0;
  logic [23:0]        pre_win = 24'd0;
  logic [WL_W-1:0]    win_len = WL_W'(WINDOW_MAX);

  word_t  stim_words [$];
  trace_t pending_traces [$];
  word_t  cur;
  trace_t want;
  bit     took = 1'b0;
  bit     steady = 1'b0;
  int     gap = 0;
  int     staged = 0;
  int     mismatches = 0;
  int     cycles = 0;

  task automatic push_trace(input logic signed [16:0] trace, input logic [5:0] idx,
                            input logic last, input status_t status);
    trace_t r;
    r.trace = trace;
    r.idx = idx;
    r.last = last;
    r.status = status;
    pending_traces.push_back(r);
  endtask

  task automatic predict_capture(input word_t w);
    longint thr;
    int     sum;
    int     num;
    int     baseline;
    int     wl;
    case (w.op)
      OP_CLEAR: begin
        fill = '0;
        seek = '0;
        halted = 1'b0;
      end
      OP_APPEND: begin
        if (fill < SAMPLE_DEPTH) begin
          sample_mem[fill] = w.value;
          stamp_mem[fill] = w.stamp;
          fill = fill + 1'b1;
        end
      end
      OP_EVENT: begin
        if (halted) begin
          push_trace('0, '0, 1'b1, STAT_ABORTED);
        end else begin
          thr = longint'(w.ev) - longint'(pre_win);
          while (seek < fill && longint'(stamp_mem[seek]) < thr)
            seek = seek + 1'b1;
          if (seek >= fill || seek + (MEAN_TAPS - 1) >= fill) begin
            halted = 1'b1;
            push_trace('0, '0, 1'b1, STAT_MISSING);
          end else begin
            sum = 0;
            for (int k = 0; k < MEAN_TAPS; k++)
              sum += int'(sample_mem[seek + k]);
            // round to nearest, floor division
            num = sum + 5;
            baseline = num / 10;
            if (num % 10 != 0 && num < 0)
              baseline--;
            wl = (win_len == 0) ? 1 : ((win_len > WINDOW_MAX) ? WINDOW_MAX : int'(win_len));
            for (int k = 0; k < wl; k++) begin
              if (seek + k < fill)
                push_trace(17'(int'(sample_mem[seek + k]) - baseline), 6'(k),
                           k == wl - 1, STAT_WINDOW);
              else
                push_trace('0, 6'(k), k == wl - 1, STAT_WINDOW);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    took = rst_n && start && !busy;
    if (took)
      predict_capture(cur);
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(0, 2);
        start <= 1'b0;
      end else if (stim_words.size() != 0) begin
        cur = stim_words.pop_front();
        start <= 1'b1;
        in_operation <= cur.op;
        in_sample_value <= cur.value;
        in_sample_time <= cur.stamp;
        in_event_time <= cur.ev;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_traces.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected word: trace %0d index %0d last %0d status %0d", $realtime,
                   out_trace_value, out_sample_index, out_last, out_status);
      end else begin
        want = pending_traces.pop_front();
        if (out_trace_value !== want.trace || out_sample_index !== want.idx ||
            out_last !== want.last || out_status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t expected trace %0d index %0d last %0d status %0d, got %0d %0d %0d %0d",
                     $realtime, want.trace, want.idx, want.last, want.status,
                     out_trace_value, out_sample_index, out_last, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("event_triggered_window_capture_unit: mismatch");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_word(input logic [1:0] op, input logic signed [15:0] value,
                            input logic [31:0] stamp, input logic [31:0] ev);
    word_t w;
    w.op = op;
    w.value = value;
    w.stamp = stamp;
    w.ev = ev;
    stim_words.push_back(w);
    staged++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_PRE_WINDOW)
      pre_win = val;
    else
      win_len = val[WL_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_quiet();
    do
      @(posedge clk);
    while (stim_words.size() != 0 || start || busy || pending_traces.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // clear, fill with ascending stamps, then events walking forward through the data
  task automatic stage_epochs(input int n_samples, input int n_events, input logic [31:0] base,
                              input int stride, input bit early);
    logic [31:0]        stamp_log [$];
    logic [31:0]        t;
    logic [31:0]        ev;
    logic [31:0]        prev_ev;
    logic [32:0]        reach;
    logic signed [15:0] v;
    int                 pos;
    int                 flavor;
    t = base;
    pos = 0;
    prev_ev = '0;
    flavor = $urandom_range(0, 5);
    queue_word(OP_CLEAR, 16'($urandom), $urandom, $urandom);
    for (int i = 0; i < n_samples; i++) begin
      t = t + $urandom_range(1, 16);
      case (flavor)
        0: v = ($urandom_range(0, 9) == 0) ? 16'sh8000 : 16'sh7FFF;
        1: v = ($urandom_range(0, 9) == 0) ? 16'sh7FFF : 16'sh8000;
        default: v = rand_sample();
      endcase
      stamp_log.push_back(t);
      queue_word(OP_APPEND, v, t, $urandom);
    end
    if (early) begin
      prev_ev = $urandom_range(0, pre_win);
      queue_word(OP_EVENT, 16'($urandom), $urandom, prev_ev);
    end
    for (int e = 0; e < n_events; e++) begin
      if ($urandom_range(0, 9) == 0)
        queue_word(2'($urandom_range(0, 3)), 16'($urandom), $urandom, $urandom);
      pos = pos + $urandom_range(0, stride);
      if (pos < n_samples)
        reach = stamp_log[pos] + pre_win + $urandom_range(0, 1);
      else
        reach = t + pre_win + $urandom_range(1, 100);
      if (reach > 33'h0FFFFFFFF)
        reach = 33'h0FFFFFFFF;
      ev = reach[31:0];
      if (ev < prev_ev)
        ev = prev_ev;
      prev_ev = ev;
      queue_word(OP_EVENT, 16'($urandom), $urandom, ev);
    end
  endtask

  initial begin
    int mark;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // empty store, then aborted, unused code, mean extremes, short tail
    queue_word(OP_EVENT, 16'($urandom), $urandom, 32'd0);
    queue_word(OP_EVENT, 16'($urandom), $urandom, 32'hFFFFFFFF);
    queue_word(OP_UNUSED, 16'($urandom), $urandom, $urandom);
    queue_word(OP_CLEAR, 16'($urandom), $urandom, $urandom);
    for (int i = 0; i < 10; i++)
      queue_word(OP_APPEND, 16'sh8000, 32'(i), $urandom);
    queue_word(OP_APPEND, 16'sh7FFF, 32'd10, $urandom);
    queue_word(OP_APPEND, 16'sh0000, 32'd11, $urandom);
    queue_word(OP_EVENT, 16'($urandom), $urandom, 32'd0);
    queue_word(OP_APPEND, 16'sh7FFF, 32'hFFFFFFFF, $urandom);
    queue_word(OP_EVENT, 16'($urandom), $urandom, 32'hFFFFFFFF);
    queue_word(OP_EVENT, 16'($urandom), $urandom, 32'hFFFFFFFF);
    wait_quiet();

    write_reg(CFG_PRE_WINDOW, 24'd0);
    write_reg(CFG_WINDOW_LENGTH, 24'd1);
    stage_epochs(20, 6, $urandom_range(0, 32'hFFF00000), 6, 1'b0);
    wait_quiet();

    write_reg(CFG_PRE_WINDOW, 24'hFFFFFF);
    write_reg(CFG_WINDOW_LENGTH, 24'(WINDOW_MAX));
    stage_epochs(24, 6, $urandom_range(0, 5000), 6, 1'b1);
    wait_quiet();

    write_reg(CFG_PRE_WINDOW, 24'($urandom_range(1, 200)));
    write_reg(CFG_WINDOW_LENGTH, 24'd0);
    stage_epochs(20, 5, $urandom_range(0, 32'hFFF00000), 6, 1'b0);
    wait_quiet();

    write_reg(CFG_PRE_WINDOW, 24'd100);
    write_reg(CFG_WINDOW_LENGTH, 24'd127);
    stage_epochs(30, 5, $urandom_range(0, 32'hFFF00000), 6, 1'b0);
    wait_quiet();

    mark = staged;
    while (staged - mark < RANDOM_WORDS) begin
      case ($urandom_range(0, 3))
        0: write_reg(CFG_PRE_WINDOW, 24'd0);
        1: write_reg(CFG_PRE_WINDOW, 24'($urandom_range(1, 200)));
        2: write_reg(CFG_PRE_WINDOW, 24'($urandom));
        default: write_reg(CFG_PRE_WINDOW, 24'hFFFFFF);
      endcase
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_WINDOW_LENGTH, 24'($urandom_range(0, 127)));
      else
        write_reg(CFG_WINDOW_LENGTH, 24'($urandom_range(1, WINDOW_MAX)));
      stage_epochs($urandom_range(10, 40), $urandom_range(2, 8),
                   $urandom_range(0, 32'hFFF00000), 6, $urandom_range(0, 3) == 0);
      if (staged - mark > RANDOM_WORDS - 90)
        steady = 1'b1;
      wait_quiet();
    end

    repeat (100) @(negedge clk);
    if (mismatches == 0 && pending_traces.size() == 0)
      $display("event_triggered_window_capture_unit: match");
    else
      $display("event_triggered_window_capture_unit: mismatch");
    $finish;
  end

endmodule
